// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file rau_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int PORT_BITS     = 64;
	localparam int SCALAR_BITS   = 63;
	localparam int MUL_BITS      = 64;

	typedef enum logic [2:0] {
		FN_ADD    = 3'd0,
		FN_ADD_NR = 3'd1,
		FN_SUB    = 3'd2,
		FN_MUL    = 3'd3,
		FN_MUL_NR = 3'd4,
		FN_DIV    = 3'd5,
		FN_SCALE  = 3'd6,
		FN_CMP    = 3'd7
	} func_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic    neg;
	} alu_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
		logic dz;
	} alu_stat_t;

endpackage

// ===== rtl/core/rau_alu.sv =====
`timescale 1ns / 1ps
module rau_alu #(
	parameter int W = rau_pkg::WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rau_pkg::alu_ctl_t          ctl,
	input  logic [W-1:0]               opa,
	input  logic [rau_pkg::MUL_BITS-1:0] opb,
	output rau_pkg::alu_stat_t         stat,
	output logic [W-1:0]               res,
	output logic [W-1:0]               rem
);
	import rau_pkg::*;

	localparam int CntW = $clog2(MUL_BITS + 1);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_RUN  = 3'b010,
		U_FIN  = 3'b100
	} ustate_t;

	ustate_t        state_q;
	alu_op_t        op_q;
	logic           neg_q;
	logic           sa_q, sb_q;
	logic           ovf_q, dz_q, done_q;
	logic [CntW-1:0] cnt_q;
	logic [W-1:0]   ma_q;
	logic [MUL_BITS-1:0] mb_q;
	logic [W+1:0]   acc_q;
	logic [W-1:0]   dvd_q, dvs_q, rm_q;
	logic [W-1:0]   res_q, rem_q;

	logic [W+1:0]   acc_sum, acc_nxt, acc_top, acc_lim;
	logic [W:0]     trial;
	logic           q_bit;
	logic [W-1:0]   opb_w, min_w;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		mag = x[W-1] ? (~x + W'(1)) : x;
	endfunction

	assign opb_w   = opb[W-1:0];
	assign min_w   = {1'b1, {(W-1){1'b0}}};
	assign acc_top = (W+2)'(1) << W;
	assign acc_lim = {3'b000, {(W-1){1'b1}}};

	// shift-add step, clamped once the product cannot fit
	always_comb begin
		acc_sum = {acc_q[W:0], 1'b0} + (mb_q[MUL_BITS-1] ? (W+2)'(ma_q) : '0);
		acc_nxt = (acc_sum >= acc_top) ? acc_top : acc_sum;
	end

	// restoring divide step
	always_comb begin
		trial = {rm_q, dvd_q[W-1]};
		q_bit = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (ctl.start) begin
						op_q  <= ctl.op;
						neg_q <= ctl.neg;
						dz_q  <= 1'b0;
						ovf_q <= 1'b0;
						if (ctl.op == OP_MUL) begin
							ma_q    <= opa;
							mb_q    <= opb;
							acc_q   <= '0;
							cnt_q   <= CntW'(MUL_BITS);
							state_q <= U_RUN;
						end else if (opb_w == '0) begin
							dz_q    <= 1'b1;
							state_q <= U_FIN;
						end else begin
							sa_q    <= opa[W-1];
							sb_q    <= opb_w[W-1];
							dvd_q   <= mag(opa);
							dvs_q   <= mag(opb_w);
							rm_q    <= '0;
							ovf_q   <= (opa == min_w) && (opb_w == '1);
							cnt_q   <= CntW'(W);
							state_q <= U_RUN;
						end
					end
				end
				U_RUN: begin
					if (op_q == OP_MUL) begin
						acc_q <= acc_nxt;
						mb_q  <= {mb_q[MUL_BITS-2:0], 1'b0};
					end else begin
						rm_q  <= q_bit ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
						dvd_q <= {dvd_q[W-2:0], q_bit};
					end
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == CntW'(1)) begin
						state_q <= U_FIN;
					end
				end
				U_FIN: begin
					if (op_q == OP_MUL) begin
						ovf_q <= acc_q > (acc_lim + (W+2)'(neg_q));
						res_q <= neg_q ? (~acc_q[W-1:0] + W'(1)) : acc_q[W-1:0];
					end else begin
						res_q <= (sa_q ^ sb_q) ? (~dvd_q + W'(1)) : dvd_q;
						rem_q <= sa_q ? (~rm_q + W'(1)) : rm_q;
					end
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign stat.dz   = dz_q;
	assign res       = res_q;
	assign rem       = rem_q;

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// The shortest path is an add without reduction on equal denominators. Each multiply,
// divide or gcd remainder step runs on the shared rau_alu; a gcd runs up to about
// 1.44*W steps.
// Throughput: one request at a time; busy drops as done rises, so the next request
// can be taken in the result cycle. Results show for one cycle on done; no stall.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops done.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     func,
	input  logic [rau_pkg::PORT_BITS-1:0]  a_num,
	input  logic [rau_pkg::PORT_BITS-1:0]  a_den,
	input  logic [rau_pkg::PORT_BITS-1:0]  b_num,
	input  logic [rau_pkg::PORT_BITS-1:0]  b_den,
	input  logic [rau_pkg::SCALAR_BITS-1:0] scalar,
	output logic                           done,
	output logic [rau_pkg::PORT_BITS-1:0]  res_num,
	output logic [rau_pkg::PORT_BITS-1:0]  res_den,
	output logic [1:0]                     order,
	output logic [1:0]                     status
);
	import rau_pkg::*;

	localparam int W = WORD_BITS;

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_ENTRY   = 17'h00002,
		S_CD_GCD  = 17'h00004,
		S_CD_FA   = 17'h00008,
		S_CD_FB   = 17'h00010,
		S_CD_XA   = 17'h00020,
		S_CD_XB   = 17'h00040,
		S_CD_DEN  = 17'h00080,
		S_MN      = 17'h00100,
		S_MD      = 17'h00200,
		S_DN      = 17'h00400,
		S_DD      = 17'h00800,
		S_SN      = 17'h01000,
		S_RED_GCD = 17'h02000,
		S_RED_N   = 17'h04000,
		S_RED_D   = 17'h08000,
		S_DONE    = 17'h10000
	} state_t;

	state_t                 state_q;
	func_t                  fn_q;
	logic signed [W-1:0]    an_q, ad_q, bn_q, bd_q;
	logic [SCALAR_BITS-1:0] sc_q;
	logic signed [W-1:0]    x_q, y_q, fa_q, fb_q, t1_q, num_q, den_q;
	logic [1:0]             st_q;
	logic                   pend_q;
	logic                   done_q;
	logic [PORT_BITS-1:0]   res_num_q, res_den_q;
	logic [1:0]             order_q, status_q;

	// shared unit request
	alu_ctl_t               u_ctl;
	alu_stat_t              u_stat;
	logic [W-1:0]           u_a, u_res, u_rem;
	logic [MUL_BITS-1:0]    u_b;
	logic signed [W-1:0]    sel_x, sel_y;
	logic                   use_unit, use_sc, gcd_st;
	alu_op_t                u_op;
	logic [1:0]             u_err;

	// shared add/subtract with overflow
	logic signed [W-1:0]    as_a, as_b;
	logic                   as_sub;
	logic [W:0]             as_sum;
	logic                   as_ovf;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		mag = x[W-1] ? (~x + W'(1)) : x;
	endfunction

	// pick unit operands for the current step
	always_comb begin
		sel_x    = '0;
		sel_y    = '0;
		use_unit = 1'b1;
		use_sc   = 1'b0;
		gcd_st   = 1'b0;
		u_op     = OP_MUL;
		unique case (state_q)
			S_CD_GCD, S_RED_GCD: begin
				u_op = OP_DIV; sel_x = x_q; sel_y = y_q; gcd_st = 1'b1;
			end
			S_CD_FA:  begin u_op = OP_DIV; sel_x = bd_q; sel_y = x_q; end
			S_CD_FB:  begin u_op = OP_DIV; sel_x = ad_q; sel_y = x_q; end
			S_CD_XA:  begin sel_x = an_q; sel_y = fa_q; end
			S_CD_XB:  begin sel_x = bn_q; sel_y = fb_q; end
			S_CD_DEN: begin sel_x = ad_q; sel_y = fa_q; end
			S_MN:     begin sel_x = an_q; sel_y = bn_q; end
			S_MD:     begin sel_x = ad_q; sel_y = bd_q; end
			S_DN:     begin sel_x = an_q; sel_y = bd_q; end
			S_DD:     begin sel_x = ad_q; sel_y = bn_q; end
			S_SN:     begin sel_x = an_q; use_sc = 1'b1; end
			S_RED_N:  begin u_op = OP_DIV; sel_x = num_q; sel_y = x_q; end
			S_RED_D:  begin u_op = OP_DIV; sel_x = den_q; sel_y = x_q; end
			default:  use_unit = 1'b0;
		endcase
		u_ctl.op    = u_op;
		u_ctl.neg   = sel_x[W-1] ^ (use_sc ? 1'b0 : sel_y[W-1]);
		u_ctl.start = use_unit && !pend_q && !(gcd_st && (y_q == '0));
		u_a         = (u_op == OP_MUL) ? mag(sel_x) : sel_x;
		if (use_sc) begin
			u_b = MUL_BITS'(sc_q);
		end else if (u_op == OP_MUL) begin
			u_b = MUL_BITS'(mag(sel_y));
		end else begin
			u_b = MUL_BITS'(sel_y);
		end
		u_err = u_stat.dz ? ST_DZ : (u_stat.ovf ? ST_OVF : ST_OK);
	end

	always_comb begin
		as_a   = (state_q == S_ENTRY) ? an_q : t1_q;
		as_b   = (state_q == S_ENTRY) ? bn_q : u_res;
		as_sub = (state_q != S_ENTRY) && (fn_q == FN_SUB);
		as_sum = as_sub ? ({as_a[W-1], as_a} - {as_b[W-1], as_b})
		                : ({as_a[W-1], as_a} + {as_b[W-1], as_b});
		as_ovf = as_sum[W] ^ as_sum[W-1];
	end

	rau_alu #(.W(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (u_ctl),
		.opa    (u_a),
		.opb    (u_b),
		.stat   (u_stat),
		.res    (u_res),
		.rem    (u_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			done_q <= 1'b0;
			if (u_ctl.start) begin
				pend_q <= 1'b1;
			end
			if (u_stat.done) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						fn_q    <= func_t'(func);
						an_q    <= a_num[W-1:0];
						ad_q    <= a_den[W-1:0];
						bn_q    <= b_num[W-1:0];
						bd_q    <= b_den[W-1:0];
						sc_q    <= scalar;
						st_q    <= ST_OK;
						order_q <= 2'b00;
						state_q <= S_ENTRY;
					end
				end
				S_ENTRY: begin
					case (fn_q)
						FN_ADD, FN_ADD_NR: begin
							if (ad_q == bd_q) begin
								num_q <= as_sum[W-1:0];
								den_q <= ad_q;
								x_q   <= as_sum[W-1:0];
								y_q   <= ad_q;
								if (as_ovf) begin
									st_q    <= ST_OVF;
									state_q <= S_DONE;
								end else begin
									state_q <= (fn_q == FN_ADD) ? S_RED_GCD : S_DONE;
								end
							end else begin
								x_q <= ad_q; y_q <= bd_q; state_q <= S_CD_GCD;
							end
						end
						FN_SUB, FN_CMP: begin
							x_q <= ad_q; y_q <= bd_q; state_q <= S_CD_GCD;
						end
						FN_MUL, FN_MUL_NR: state_q <= S_MN;
						FN_DIV:            state_q <= S_DN;
						default:           state_q <= S_SN;
					endcase
				end
				S_CD_GCD, S_RED_GCD: begin
					if (!pend_q && (y_q == '0)) begin
						state_q <= (state_q == S_CD_GCD) ? S_CD_FA : S_RED_N;
					end else if (u_stat.done) begin
						x_q <= y_q;
						y_q <= u_rem;
					end
				end
				S_DONE: begin
					done_q    <= 1'b1;
					res_num_q <= (st_q == ST_OK) ? PORT_BITS'(num_q) : '0;
					res_den_q <= (st_q == ST_OK) ? PORT_BITS'(den_q) : '0;
					order_q   <= (st_q == ST_OK) ? order_q : 2'b00;
					status_q  <= st_q;
					state_q   <= S_IDLE;
				end
				default: begin
					if (u_stat.done) begin
						if (u_err != ST_OK) begin
							st_q    <= u_err;
							state_q <= S_DONE;
						end else begin
							case (state_q)
								S_CD_FA: begin fa_q <= u_res; state_q <= S_CD_FB; end
								S_CD_FB: begin fb_q <= u_res; state_q <= S_CD_XA; end
								S_CD_XA: begin t1_q <= u_res; state_q <= S_CD_XB; end
								S_CD_XB: begin
									if (fn_q == FN_CMP) begin
										num_q   <= '0;
										den_q   <= '0;
										order_q <= (t1_q > $signed(u_res)) ? 2'b01 :
										           ((t1_q < $signed(u_res)) ? 2'b11 : 2'b00);
										state_q <= S_DONE;
									end else if (as_ovf) begin
										st_q    <= ST_OVF;
										state_q <= S_DONE;
									end else begin
										num_q   <= as_sum[W-1:0];
										state_q <= S_CD_DEN;
									end
								end
								S_CD_DEN: begin
									den_q   <= u_res;
									x_q     <= num_q;
									y_q     <= u_res;
									state_q <= (fn_q == FN_ADD_NR) ? S_DONE : S_RED_GCD;
								end
								S_MN: begin num_q <= u_res; state_q <= S_MD; end
								S_MD: begin
									den_q   <= u_res;
									x_q     <= num_q;
									y_q     <= u_res;
									state_q <= (fn_q == FN_MUL) ? S_RED_GCD : S_DONE;
								end
								S_DN: begin num_q <= u_res; state_q <= S_DD; end
								S_DD: begin
									den_q <= u_res; x_q <= num_q; y_q <= u_res;
									state_q <= S_RED_GCD;
								end
								S_SN: begin
									num_q <= u_res; den_q <= ad_q;
									x_q <= u_res; y_q <= ad_q;
									state_q <= S_RED_GCD;
								end
								S_RED_N: begin num_q <= u_res; state_q <= S_RED_D; end
								S_RED_D: begin den_q <= u_res; state_q <= S_DONE; end
								default: state_q <= S_DONE;
							endcase
						end
					end
				end
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign order   = order_q;
	assign status  = status_q;

endmodule

// ===== rtl/core/rau_check.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rau_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [rau_pkg::PORT_BITS-1:0] res_num,
	input logic [rau_pkg::PORT_BITS-1:0] res_den,
	input logic [1:0]                    order,
	input logic [1:0]                    status
);
	import rau_pkg::*;

	// an accepted request keeps the unit busy
	`ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// a result is a single-cycle strobe
	`ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	// a failed request returns all-zero payload
	`ASSERT_IMP(a_err_zero, clk, arst_n, done && (status != ST_OK), (res_num == '0) && (res_den == '0) && (order == 2'b00))
	// a compare result carries no fraction
	`ASSERT_IMP(a_cmp_zero, clk, arst_n, done && (order != 2'b00), (res_num == '0) && (res_den == '0))
	// status holds a defined code
	`ASSERT_IMP(a_status_code, clk, arst_n, done, (status == ST_OK) || (status == ST_OVF) || (status == ST_DZ))

endmodule

bind rational_arithmetic_unit rau_check u_rau_check (.*);
